### rtl/jsu_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the JSON string unescaper.
// Used by jsu_front, jsu_queue, jsu_back, the top level and the checker.
package jsu_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NO_QUOTE = 3'd1;
  localparam logic [2:0] ERR_EARLY    = 3'd2;
  localparam logic [2:0] ERR_ESCAPE   = 3'd3;
  localparam logic [2:0] ERR_HEX      = 3'd4;
  localparam logic [2:0] ERR_NO_LOW   = 3'd5;

  // Characters the parser looks for.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  // Depth of the command queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [8:0] {
    PH_IDLE = 9'b000000001,
    PH_BODY = 9'b000000010,
    PH_ESC  = 9'b000000100,
    PH_HEX1 = 9'b000001000,
    PH_BSL2 = 9'b000010000,
    PH_U2   = 9'b000100000,
    PH_HEX2 = 9'b001000000,
    PH_DONE = 9'b010000000,
    PH_ERR  = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [2:0]      nbytes;
    logic [3:0][7:0] bytes;
  } utf8_t;

  // One command: all results that one input byte causes.
  typedef struct packed {
    logic [2:0]      nbytes;
    logic [3:0][7:0] bytes;
    logic            has_stat;
    logic [1:0]      kind;
    logic [2:0]      code;
  } cmd_t;

  // Returns {valid, value} for an ASCII hex digit.
  function automatic logic [4:0] hex_decode(input logic [7:0] ch);
    logic [7:0] diff;
    diff = 8'h00;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      diff = ch - 8'h30;
      return {1'b1, diff[3:0]};
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      diff = ch - 8'h57;
      return {1'b1, diff[3:0]};
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      diff = ch - 8'h37;
      return {1'b1, diff[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t u;
    u.nbytes = 3'd0;
    u.bytes  = '0;
    if (cp <= 21'h7F) begin
      u.nbytes   = 3'd1;
      u.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      u.nbytes   = 3'd2;
      u.bytes[0] = {3'b110, cp[10:6]};
      u.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      u.nbytes   = 3'd3;
      u.bytes[0] = {4'b1110, cp[15:12]};
      u.bytes[1] = {2'b10, cp[11:6]};
      u.bytes[2] = {2'b10, cp[5:0]};
    end else if (cp <= 21'h10FFFF) begin
      u.nbytes   = 3'd4;
      u.bytes[0] = {5'b11110, cp[20:18]};
      u.bytes[1] = {2'b10, cp[17:12]};
      u.bytes[2] = {2'b10, cp[11:6]};
      u.bytes[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

endpackage

### rtl/jsu_front.sv
`timescale 1ns / 1ps
// Front end: parses one byte per accepted item and builds one command that
// lists every result the byte causes. Depends on jsu_pkg.
module jsu_front import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] byte_in,
  input  logic       buffer_end,
  output logic       cmd_push,
  output cmd_t       cmd
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  digit_r, digit_nxt;
  logic [15:0] first_r, first_nxt;
  logic [11:0] second_r, second_nxt;
  logic [4:0]  hex;
  logic [15:0] unit_full;
  logic [20:0] cp;
  utf8_t       enc;
  logic        do_enc;

  assign hex = hex_decode(byte_in);

  always_comb begin
    phase_nxt  = phase_r;
    digit_nxt  = digit_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    cmd        = '0;
    do_enc     = 1'b0;
    cp         = 21'd0;
    unit_full  = 16'd0;

    case (phase_r)
      PH_IDLE: begin
        if (byte_in == CH_QUOTE) begin
          phase_nxt = PH_BODY;
        end else begin
          cmd.has_stat = 1'b1;
          cmd.kind     = KIND_ERR;
          cmd.code     = ERR_NO_QUOTE;
          phase_nxt    = PH_ERR;
        end
      end
      PH_BODY: begin
        if (byte_in == CH_BSL) begin
          phase_nxt = PH_ESC;
        end else if (byte_in == CH_QUOTE) begin
          cmd.has_stat = 1'b1;
          cmd.kind     = KIND_DONE;
          phase_nxt    = PH_DONE;
        end else begin
          cmd.nbytes   = 3'd1;
          cmd.bytes[0] = byte_in;
        end
      end
      PH_ESC: begin
        phase_nxt  = PH_BODY;
        cmd.nbytes = 3'd1;
        case (byte_in)
          CH_QUOTE, CH_SLASH, CH_BSL: cmd.bytes[0] = byte_in;
          CH_B: cmd.bytes[0] = 8'h08;
          CH_F: cmd.bytes[0] = 8'h0C;
          CH_N: cmd.bytes[0] = 8'h0A;
          CH_R: cmd.bytes[0] = 8'h0D;
          CH_T: cmd.bytes[0] = 8'h09;
          CH_U: begin
            cmd.nbytes = 3'd0;
            phase_nxt  = PH_HEX1;
            digit_nxt  = 2'd0;
            first_nxt  = 16'd0;
          end
          default: begin
            cmd.nbytes   = 3'd0;
            cmd.has_stat = 1'b1;
            cmd.kind     = KIND_ERR;
            cmd.code     = ERR_ESCAPE;
            phase_nxt    = PH_ERR;
          end
        endcase
      end
      PH_HEX1: begin
        if (!hex[4]) begin
          cmd.has_stat = 1'b1;
          cmd.kind     = KIND_ERR;
          cmd.code     = ERR_HEX;
          phase_nxt    = PH_ERR;
        end else begin
          unit_full = {first_r[11:0], hex[3:0]};
          first_nxt = unit_full;
          if (digit_r == 2'd3) begin
            digit_nxt = 2'd0;
            if (unit_full >= 16'hD800 && unit_full <= 16'hDBFF) begin
              phase_nxt = PH_BSL2;
            end else begin
              cp        = {5'd0, unit_full};
              do_enc    = 1'b1;
              phase_nxt = PH_BODY;
            end
          end else begin
            digit_nxt = digit_r + 2'd1;
          end
        end
      end
      PH_BSL2: begin
        if (byte_in == CH_BSL) begin
          phase_nxt = PH_U2;
        end else begin
          cmd.has_stat = 1'b1;
          cmd.kind     = KIND_ERR;
          cmd.code     = ERR_NO_LOW;
          phase_nxt    = PH_ERR;
        end
      end
      PH_U2: begin
        if (byte_in == CH_U) begin
          phase_nxt  = PH_HEX2;
          digit_nxt  = 2'd0;
          second_nxt = 12'd0;
        end else begin
          cmd.has_stat = 1'b1;
          cmd.kind     = KIND_ERR;
          cmd.code     = ERR_NO_LOW;
          phase_nxt    = PH_ERR;
        end
      end
      PH_HEX2: begin
        if (!hex[4]) begin
          cmd.has_stat = 1'b1;
          cmd.kind     = KIND_ERR;
          cmd.code     = ERR_HEX;
          phase_nxt    = PH_ERR;
        end else begin
          second_nxt = {second_r[7:0], hex[3:0]};
          if (digit_r == 2'd3) begin
            // Only the low ten bits of each unit form the pair's code point.
            cp        = 21'h10000 + {1'b0, first_r[9:0], second_r[5:0], hex[3:0]};
            do_enc    = 1'b1;
            digit_nxt = 2'd0;
            phase_nxt = PH_BODY;
          end else begin
            digit_nxt = digit_r + 2'd1;
          end
        end
      end
      default: begin
        // Done or error: bytes are dropped until the buffer ends.
      end
    endcase

    enc = utf8_encode(cp);
    if (do_enc) begin
      cmd.nbytes = enc.nbytes;
      cmd.bytes  = enc.bytes;
    end

    if (buffer_end) begin
      if (phase_nxt inside {PH_BODY, PH_ESC, PH_HEX1, PH_BSL2, PH_U2, PH_HEX2}) begin
        cmd.has_stat = 1'b1;
        cmd.kind     = KIND_ERR;
        cmd.code     = ERR_EARLY;
      end
      phase_nxt = PH_IDLE;
      digit_nxt = 2'd0;
    end
  end

  assign cmd_push = accept && (cmd.nbytes != 3'd0 || cmd.has_stat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      digit_r  <= 2'd0;
      first_r  <= 16'd0;
      second_r <= 12'd0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      digit_r  <= digit_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

### rtl/jsu_queue.sv
`timescale 1ns / 1ps
// Short command queue that decouples the parser from the result sequencer.
// Depends on jsu_pkg.
module jsu_queue import jsu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = slot_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_cmd;
    end
  end

endmodule

### rtl/jsu_back.sv
`timescale 1ns / 1ps
// Back end: holds one command and hands out its results one per pop.
// Depends on jsu_pkg.
module jsu_back import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       head,
  input  logic       q_empty,
  output logic       q_pop,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] data_byte,
  output logic [1:0] kind,
  output logic [2:0] error_code,
  output logic       last
);

  cmd_t       cur_r;
  logic       valid_r, valid_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [2:0] total;
  logic       take, finish;

  assign total = cur_r.nbytes + {2'd0, cur_r.has_stat};
  assign empty = !valid_r;
  assign last  = (idx_r == total - 3'd1);

  always_comb begin
    if (idx_r < cur_r.nbytes) begin
      data_byte  = cur_r.bytes[idx_r[1:0]];
      kind       = KIND_DATA;
      error_code = ERR_NONE;
    end else begin
      data_byte  = 8'd0;
      kind       = cur_r.kind;
      error_code = cur_r.code;
    end
  end

  assign take   = valid_r && pop;
  assign finish = take && last;
  // A new command is loaded as soon as the current one has handed out its
  // final result, so results leave back to back.
  assign q_pop  = (!valid_r || finish) && !q_empty;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (!valid_r || finish) begin
      valid_nxt = !q_empty;
      idx_nxt   = 3'd0;
    end else if (take) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 3'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= head;
    end
  end

endmodule

### rtl/json_string_unescape.sv
`timescale 1ns / 1ps
// Streaming unescaper for one double-quoted JSON-style string per buffer. It
// takes one raw byte per cycle while not full (push/full) and returns decoded
// bytes, then a success or error marker, on a queue-style result port
// (empty/pop). Each byte is parsed combinationally by the front end and turned
// into one command of up to five results; a four-entry command queue feeds
// the back end, which hands out one result per cycle while pop is high. A
// surrogate pair expands to four UTF-8 bytes, but from twelve input bytes, so
// the parser, not the result side, sets the sustained rate when such escapes
// are dense. When nothing is waiting ahead of it, the first result of a byte
// is written into the command queue, then into the back end's command
// register, and then shows on the result ports. Depends on jsu_pkg, jsu_front,
// jsu_queue and jsu_back.
module json_string_unescape import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_in,
  input  logic       in_buffer_end,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_data_byte,
  output logic [1:0] out_kind,
  output logic [2:0] out_error_code,
  output logic       out_last
);

  cmd_t cmd, head;
  logic cmd_push, q_pop, q_empty, q_full;

  assign full = q_full;

  jsu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (push && !q_full),
    .byte_in    (in_byte_in),
    .buffer_end (in_buffer_end),
    .cmd_push   (cmd_push),
    .cmd        (cmd)
  );

  jsu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd),
    .pop      (q_pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .data_byte  (out_data_byte),
    .kind       (out_kind),
    .error_code (out_error_code),
    .last       (out_last)
  );

endmodule

### rtl/jsu_checker.sv
`timescale 1ns / 1ps
// Port-level checker for json_string_unescape, attached by the bind below.
// Depends on jsu_pkg.
module jsu_checker import jsu_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       push,
  input logic       full,
  input logic [7:0] in_byte_in,
  input logic       in_buffer_end,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_data_byte,
  input logic [1:0] out_kind,
  input logic [2:0] out_error_code,
  input logic       out_last
);

  // Nothing is waiting right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result waiting right after reset");

  // A result that is not taken stays on the ports unchanged.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data_byte) && $stable(out_kind)
      && $stable(out_error_code) && $stable(out_last)))
    else $error("stalled result changed");

  // A success or error marker always closes the results of its byte.
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind != KIND_DATA) |-> (out_last && out_data_byte == 8'd0))
    else $error("status result not last or carries data");

  // Error codes appear only on error results.
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind != KIND_ERR) |-> (out_error_code == ERR_NONE))
    else $error("error code on a non-error result");

  // A waiting result never shows unknown bits.
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> !$isunknown({out_data_byte, out_kind, out_error_code, out_last}))
    else $error("waiting result has unknown bits");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (.*);

### bench/json_string_unescape_chk.sv
`timescale 1ns / 1ps
// Checker for the JSON string unescaper: it watches the request and result
// channels, predicts every result from the accepted bytes and compares them.
// Depends on jsu_pkg for the result kinds, error codes, characters and phases.
module json_string_unescape_chk import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] in_byte_in,
  input  logic       in_buffer_end,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_data_byte,
  input  logic [1:0] out_kind,
  input  logic [2:0] out_error_code,
  input  logic       out_last,
  output int         fail_count,
  output int         pending,
  output int         results_seen
);

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [2:0] code;
    logic       last;
  } result_t;

  result_t    expected_results[$];
  result_t    byte_results[$];

  // Parser state as the block should hold it.
  phase_t     parse_phase;
  logic [1:0] hex_digits;
  logic [15:0] high_unit;
  logic [15:0] low_unit;

  function automatic int hex_val(input logic [7:0] ch);
    if (ch >= 8'h30 && ch <= 8'h39) return ch - 8'h30;
    if (ch >= 8'h61 && ch <= 8'h66) return ch - 8'h61 + 10;
    if (ch >= 8'h41 && ch <= 8'h46) return ch - 8'h41 + 10;
    return -1;
  endfunction

  task queue_result(input logic [7:0] data, input logic [1:0] kind, input logic [2:0] code);
    result_t r;
    r.data = data;
    r.kind = kind;
    r.code = code;
    r.last = 1'b0;
    byte_results.push_back(r);
  endtask

  task queue_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      queue_result(cp[7:0], KIND_DATA, ERR_NONE);
    end else if (cp < 21'h800) begin
      queue_result(8'hC0 | cp[10:6], KIND_DATA, ERR_NONE);
      queue_result(8'h80 | cp[5:0], KIND_DATA, ERR_NONE);
    end else if (cp < 21'h10000) begin
      queue_result(8'hE0 | cp[15:12], KIND_DATA, ERR_NONE);
      queue_result(8'h80 | cp[11:6], KIND_DATA, ERR_NONE);
      queue_result(8'h80 | cp[5:0], KIND_DATA, ERR_NONE);
    end else begin
      queue_result(8'hF0 | cp[20:18], KIND_DATA, ERR_NONE);
      queue_result(8'h80 | cp[17:12], KIND_DATA, ERR_NONE);
      queue_result(8'h80 | cp[11:6], KIND_DATA, ERR_NONE);
      queue_result(8'h80 | cp[5:0], KIND_DATA, ERR_NONE);
    end
  endtask

  task fail_parse(input logic [2:0] code);
    queue_result(8'h00, KIND_ERR, code);
    parse_phase = PH_ERR;
  endtask

  // Advances the parser by one byte and appends the results it causes.
  task decode_byte(input logic [7:0] ch, input logic buf_last);
    int      nib;
    result_t r;
    byte_results.delete();
    case (parse_phase)
      PH_IDLE: begin
        if (ch == CH_QUOTE) parse_phase = PH_BODY;
        else fail_parse(ERR_NO_QUOTE);
      end
      PH_BODY: begin
        if (ch == CH_BSL) begin
          parse_phase = PH_ESC;
        end else if (ch == CH_QUOTE) begin
          queue_result(8'h00, KIND_DONE, ERR_NONE);
          parse_phase = PH_DONE;
        end else begin
          queue_result(ch, KIND_DATA, ERR_NONE);
        end
      end
      PH_ESC: begin
        parse_phase = PH_BODY;
        case (ch)
          CH_QUOTE, CH_SLASH, CH_BSL: queue_result(ch, KIND_DATA, ERR_NONE);
          CH_B: queue_result(8'h08, KIND_DATA, ERR_NONE);
          CH_F: queue_result(8'h0C, KIND_DATA, ERR_NONE);
          CH_N: queue_result(8'h0A, KIND_DATA, ERR_NONE);
          CH_R: queue_result(8'h0D, KIND_DATA, ERR_NONE);
          CH_T: queue_result(8'h09, KIND_DATA, ERR_NONE);
          CH_U: begin
            parse_phase = PH_HEX1;
            hex_digits = 2'd0;
            high_unit = 16'h0000;
          end
          default: fail_parse(ERR_ESCAPE);
        endcase
      end
      PH_HEX1: begin
        nib = hex_val(ch);
        if (nib < 0) begin
          fail_parse(ERR_HEX);
        end else begin
          high_unit = {high_unit[11:0], nib[3:0]};
          if (hex_digits == 2'd3) begin
            hex_digits = 2'd0;
            // A high surrogate waits for its partner; anything else is a code point.
            if (high_unit >= 16'hD800 && high_unit <= 16'hDBFF) begin
              parse_phase = PH_BSL2;
            end else begin
              queue_utf8({5'd0, high_unit});
              parse_phase = PH_BODY;
            end
          end else begin
            hex_digits = hex_digits + 2'd1;
          end
        end
      end
      PH_BSL2: begin
        if (ch == CH_BSL) parse_phase = PH_U2;
        else fail_parse(ERR_NO_LOW);
      end
      PH_U2: begin
        if (ch == CH_U) begin
          parse_phase = PH_HEX2;
          hex_digits = 2'd0;
          low_unit = 16'h0000;
        end else begin
          fail_parse(ERR_NO_LOW);
        end
      end
      PH_HEX2: begin
        nib = hex_val(ch);
        if (nib < 0) begin
          fail_parse(ERR_HEX);
        end else begin
          low_unit = {low_unit[11:0], nib[3:0]};
          if (hex_digits == 2'd3) begin
            hex_digits = 2'd0;
            // The second unit is not range checked: only its low ten bits count.
            queue_utf8(21'h10000 + {1'b0, high_unit[9:0], low_unit[9:0]});
            parse_phase = PH_BODY;
          end else begin
            hex_digits = hex_digits + 2'd1;
          end
        end
      end
      default: ;
    endcase

    if (buf_last) begin
      if (parse_phase inside {PH_BODY, PH_ESC, PH_HEX1, PH_BSL2, PH_U2, PH_HEX2})
        queue_result(8'h00, KIND_ERR, ERR_EARLY);
      parse_phase = PH_IDLE;
      hex_digits = 2'd0;
    end

    for (int i = 0; i < byte_results.size(); i++) begin
      r = byte_results[i];
      r.last = (i == byte_results.size() - 1);
      expected_results.push_back(r);
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst_n) begin
      parse_phase = PH_IDLE;
      hex_digits = 2'd0;
      high_unit = 16'h0000;
      low_unit = 16'h0000;
      expected_results.delete();
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result %02h kind %0d code %0d arrived with nothing expected",
                 out_data_byte, out_kind, out_error_code);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data_byte !== want.data) begin
            $error("data_byte: expected %02h, got %02h", want.data, out_data_byte);
            fail_count++;
          end
          if (out_kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_kind);
            fail_count++;
          end
          if (out_error_code !== want.code) begin
            $error("error_code: expected %0d, got %0d", want.code, out_error_code);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_last);
            fail_count++;
          end
        end
      end
      if (push && !full) decode_byte(in_byte_in, in_buffer_end);
    end
    pending = expected_results.size();
  end

endmodule

### bench/json_string_unescape_tb.sv
`timescale 1ns / 1ps
// Top of the JSON string unescaper testbench: clock, reset, byte buffers and
// flow control. Depends on jsu_pkg, json_string_unescape and its checker.
module json_string_unescape_tb;
  import jsu_pkg::*;

  localparam int LIMIT       = 200000;
  localparam int HOLD_CYCLES = 300;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte_in = 8'h00;
  logic       in_buffer_end = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_data_byte;
  logic [1:0] out_kind;
  logic [2:0] out_error_code;
  logic       out_last;

  int fail_count;
  int pending;
  int results_seen;

  int idle_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int buffers_sent = 0;
  int cycles = 0;
  logic hold_req = 1'b0;
  logic hold_seen;
  int   hold_left;

  logic [7:0] buf_bytes[$];
  logic [7:0] simple_escapes[8] = '{CH_QUOTE, CH_SLASH, CH_BSL, CH_B, CH_F, CH_N, CH_R, CH_T};

  always #5 clk = ~clk;

  json_string_unescape i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_byte_in    (in_byte_in),
    .in_buffer_end (in_buffer_end),
    .empty         (empty),
    .pop           (pop),
    .out_data_byte (out_data_byte),
    .out_kind      (out_kind),
    .out_error_code(out_error_code),
    .out_last      (out_last)
  );

  json_string_unescape_chk i_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_byte_in    (in_byte_in),
    .in_buffer_end (in_buffer_end),
    .empty         (empty),
    .pop           (pop),
    .out_data_byte (out_data_byte),
    .out_kind      (out_kind),
    .out_error_code(out_error_code),
    .out_last      (out_last),
    .fail_count    (fail_count),
    .pending       (pending),
    .results_seen  (results_seen)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request from the sender.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      hold_seen = hold_req;
      hold_left = 0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + nib;
    if ($urandom_range(1)) return 8'h41 + nib - 4'd10;
    return 8'h61 + nib - 4'd10;
  endfunction

  task put_str(input string s);
    for (int i = 0; i < s.len(); i++) buf_bytes.push_back(s[i]);
  endtask

  task put_unit(input logic [15:0] unit);
    buf_bytes.push_back(CH_BSL);
    buf_bytes.push_back(CH_U);
    for (int i = 3; i >= 0; i--) buf_bytes.push_back(hex_char(unit[i*4 +: 4]));
  endtask

  // Offers one byte and holds it until the block takes the request.
  task send_byte(input logic [7:0] b, input logic buf_last);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    in_byte_in <= b;
    in_buffer_end <= buf_last;
    push <= 1'b1;
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  task send_buffer();
    for (int i = 0; i < buf_bytes.size(); i++)
      send_byte(buf_bytes[i], i == buf_bytes.size() - 1);
    buffers_sent++;
    buf_bytes.delete();
  endtask

  // Stops offering and returns at a falling edge once every result is back.
  task drain();
    push <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Mostly well-formed strings with random content; a quarter get broken.
  task make_random_buffer();
    int         nseg;
    int         pos;
    logic [7:0] b;
    logic [15:0] unit;
    buf_bytes.delete();
    buf_bytes.push_back(CH_QUOTE);
    nseg = $urandom_range(0, 6);
    for (int s = 0; s < nseg; s++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSL);
          buf_bytes.push_back(b);
        end
        4, 5: begin
          buf_bytes.push_back(CH_BSL);
          buf_bytes.push_back(simple_escapes[$urandom_range(0, 7)]);
        end
        6, 7: begin
          case ($urandom_range(0, 3))
            0: unit = 16'($urandom_range(16'h0000, 16'h007F));
            1: unit = 16'($urandom_range(16'h0080, 16'h07FF));
            2: begin
              unit = 16'($urandom_range(16'h0800, 16'hFFFF));
              if (unit >= 16'hD800 && unit <= 16'hDBFF) unit = unit ^ 16'h4000;
            end
            default: unit = 16'($urandom_range(16'hDC00, 16'hDFFF));
          endcase
          put_unit(unit);
        end
        default: begin
          put_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
          if ($urandom_range(3) != 0) put_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
          else put_unit(16'($urandom_range(16'h0000, 16'hFFFF)));
        end
      endcase
    end
    buf_bytes.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 2)) buf_bytes.push_back(8'($urandom_range(0, 255)));

    if ($urandom_range(3) == 0) begin
      case ($urandom_range(0, 2))
        0: if (buf_bytes.size() > 1)
             buf_bytes = buf_bytes[0 : $urandom_range(0, buf_bytes.size() - 2)];
        1: begin
          pos = $urandom_range(1, buf_bytes.size() - 1);
          case ($urandom_range(0, 3))
            0: buf_bytes[pos] = CH_BSL;
            1: buf_bytes[pos] = CH_QUOTE;
            2: buf_bytes[pos] = 8'h47;
            default: buf_bytes[pos] = 8'($urandom_range(0, 255));
          endcase
        end
        default: begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
          buf_bytes[0] = b;
        end
      endcase
    end
  endtask

  task run_phase(input int idle, input int stall, input logic long_hold, input int n_bytes);
    int goal;
    drain();
    idle_pct = idle;
    stall_pct = stall;
    @(posedge clk);
    // The result side stops for a long while so the block fills and pushes back.
    if (long_hold) hold_req <= ~hold_req;
    goal = bytes_sent + n_bytes;
    while (bytes_sent < goal) begin
      make_random_buffer();
      send_buffer();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // No opening quote, on the largest byte value.
    buf_bytes.push_back(8'hFF);
    send_buffer();
    // Byte extremes, every simple escape, then bytes after the close are dropped.
    buf_bytes.push_back(CH_QUOTE);
    buf_bytes.push_back(8'h00);
    buf_bytes.push_back(8'hFF);
    put_str("\\\"\\/\\\\\\b\\f\\n\\r\\t\"z");
    send_buffer();
    // Unit of zero and the highest pair, then the buffer ends inside the string.
    put_str("\"\\u0000\\uDBFF\\uDFFF");
    send_buffer();
    // Unknown escape with bytes after the error.
    put_str("\"\\qab");
    send_buffer();
    // Bad hex digit, and a high surrogate without its second unit.
    put_str("\"\\uG");
    send_buffer();
    put_str("\"\\uD800x");
    send_buffer();
    // Buffer ends right after the opening quote.
    put_str("\"");
    send_buffer();

    run_phase(0, 0, 1'b0, 45);
    run_phase(51, 0, 1'b0, 45);
    run_phase(0, 51, 1'b1, 45);
    run_phase(33, 33, 1'b0, 45);
    drain();
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes in %0d buffers under four flow-control mixes; %0d results checked.",
             bytes_sent, buffers_sent, results_seen);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
